### rtl/tfrev_pkg.sv
// Package for the three-tap feedback reverb: command/status structs, register
// indexes, tap weights and fixed-point constants. No dependencies.
package tfrev_pkg;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_TAP_DELAY_ONE   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TAP_DELAY_TWO   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TAP_DELAY_THREE = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DECAY_GAIN      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WET_MIX         = 3'd4;

   localparam logic [15:0] RST_TAP_DELAY_ONE   = 16'd4800;
   localparam logic [15:0] RST_TAP_DELAY_TWO   = 16'd6720;
   localparam logic [15:0] RST_TAP_DELAY_THREE = 16'd9120;
   localparam logic [14:0] RST_DECAY_GAIN      = 15'd16384;
   localparam logic [15:0] RST_WET_MIX         = 16'd16384;

   localparam logic [14:0] DECAY_LIMIT = 15'd32440;
   localparam logic [15:0] MIX_LIMIT   = 16'd32768;
   localparam logic [15:0] Q15_ONE     = 16'd32768;

   localparam int DELAY_BITS = 16;
   localparam int ROUND_REV  = 32768;
   localparam int ROUND_Q15  = 16384;
   localparam int REV_SHIFT  = 16;
   localparam int Q15_SHIFT  = 15;

   localparam logic [1:0] TAP_ONE   = 2'd0;
   localparam logic [1:0] TAP_TWO   = 2'd1;
   localparam logic [1:0] TAP_THREE = 2'd2;

   // Q16 weights: 1/3, 0.7/3, 0.5/3
   localparam logic [15:0] W_TAP_ONE   = 16'd21845;
   localparam logic [15:0] W_TAP_TWO   = 16'd15292;
   localparam logic [15:0] W_TAP_THREE = 16'd10923;

   typedef struct packed {
      logic       take_in;
      logic       quo_en;
      logic [1:0] quo_sel;
      logic       rem_en;
      logic       rd_en;
      logic       acc_en;
      logic       acc_clr;
      logic [1:0] acc_sel;
      logic       rev_en;
      logic       mul_en;
      logic       finish;
      logic       clr_step;
   } tfrev_cmd_type;

   typedef struct packed {
      logic wp_last;
   } tfrev_sts_type;

   function automatic logic [15:0] tap_weight(input logic [1:0] sel);
      logic [15:0] w;
      unique case (sel)
         TAP_ONE:   w = W_TAP_ONE;
         TAP_TWO:   w = W_TAP_TWO;
         TAP_THREE: w = W_TAP_THREE;
         default:   w = W_TAP_ONE;
      endcase
      return w;
   endfunction

endpackage

### rtl/tfrev_if.sv
// Valid/ready channel interfaces for the reverb's request and response items.
// No dependencies.
interface tfrev_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface tfrev_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

### rtl/tfrev_ctrl.sv
// Reverb controller: clearing pass, item step sequencer, response valid.
// Depends on tfrev_pkg.
module tfrev_ctrl import tfrev_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  tfrev_sts_type sts,
   output tfrev_cmd_type cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   localparam logic [3:0] STEP_FIRST     = 4'd0;
   localparam logic [3:0] STEP_QUO_LAST  = 4'd2;
   localparam logic [3:0] STEP_REM_FIRST = 4'd1;
   localparam logic [3:0] STEP_REM_LAST  = 4'd3;
   localparam logic [3:0] STEP_RD_FIRST  = 4'd2;
   localparam logic [3:0] STEP_RD_LAST   = 4'd4;
   localparam logic [3:0] STEP_ACC_FIRST = 4'd3;
   localparam logic [3:0] STEP_ACC_LAST  = 4'd5;
   localparam logic [3:0] STEP_REV       = 4'd6;
   localparam logic [3:0] STEP_MUL       = 4'd7;
   localparam logic [3:0] STEP_FIN       = 4'd8;

   logic [1:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic [3:0] acc_step;

   assign acc_step  = step_ff - STEP_ACC_FIRST;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      cmd          = '0;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.wp_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_in = 1'b1;
               state_in    = ST_RUN;
               step_in     = STEP_FIRST;
            end
         end
         ST_RUN: begin
            cmd.quo_en  = (step_ff <= STEP_QUO_LAST);
            cmd.quo_sel = step_ff[1:0];
            cmd.rem_en  = (step_ff >= STEP_REM_FIRST) && (step_ff <= STEP_REM_LAST);
            cmd.rd_en   = (step_ff >= STEP_RD_FIRST) && (step_ff <= STEP_RD_LAST);
            cmd.acc_en  = (step_ff >= STEP_ACC_FIRST) && (step_ff <= STEP_ACC_LAST);
            cmd.acc_clr = (step_ff == STEP_ACC_FIRST);
            cmd.acc_sel = acc_step[1:0];
            cmd.rev_en  = (step_ff == STEP_REV);
            cmd.mul_en  = (step_ff == STEP_MUL);
            if (step_ff == STEP_FIN) begin
               if (!out_valid_ff || rsp_ready) begin
                  cmd.finish   = 1'b1;
                  out_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= STEP_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

### rtl/tfrev_dp.sv
// Reverb datapath: config registers, delay memory, tap address reduction,
// tap accumulator, feedback/mix products, saturation. Depends on tfrev_pkg.
module tfrev_dp import tfrev_pkg::*; #(
   parameter int BUFFER_DEPTH = 65536,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tfrev_cmd_type                 cmd,
   output tfrev_sts_type                 sts,
   input  logic                          csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_write_data,
   input  logic signed [SAMPLE_BITS-1:0] in_sample,
   output logic signed [SAMPLE_BITS-1:0] out_sample
);

   localparam int ADDR_BITS  = $clog2(BUFFER_DEPTH);
   localparam int QSH        = DELAY_BITS + ADDR_BITS;
   localparam int RECIP_BITS = 18;
   localparam logic [RECIP_BITS-1:0] RECIP =
      RECIP_BITS'((64'd1 << QSH) / BUFFER_DEPTH);
   localparam int QP_BITS  = DELAY_BITS + RECIP_BITS;
   localparam int RP_BITS  = DELAY_BITS + ADDR_BITS + 1;
   localparam int ACC_BITS = SAMPLE_BITS + 17;
   localparam int SUM_BITS = SAMPLE_BITS + 18;
   localparam logic signed [SUM_BITS-1:0] SAT_HI =
      SUM_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

   function automatic logic signed [SAMPLE_BITS-1:0] sat(
      input logic signed [SUM_BITS-1:0] v);
      logic signed [SAMPLE_BITS-1:0] r;
      if (v > SAT_HI) begin
         r = SAMPLE_BITS'(SAT_HI);
      end else if (v < SAT_LO) begin
         r = SAMPLE_BITS'(SAT_LO);
      end else begin
         r = SAMPLE_BITS'(v);
      end
      return r;
   endfunction

   logic [15:0] tap_delay_one_ff, tap_delay_two_ff, tap_delay_three_ff;
   logic [14:0] decay_gain_ff;
   logic [15:0] wet_mix_ff;

   logic signed [SAMPLE_BITS-1:0] mem [BUFFER_DEPTH];

   logic [ADDR_BITS-1:0]          wp_ff, wp_in;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic [DELAY_BITS-1:0]         dq_ff, d_sel;
   logic [DELAY_BITS-1:0]         q_ff, q_in;
   logic [QP_BITS-1:0]            qprod;
   logic [RP_BITS-1:0]            qd, diff;
   logic [ADDR_BITS-1:0]          rem_ff, rem_in;
   logic [ADDR_BITS:0]            rd_addr_wide;
   logic [ADDR_BITS-1:0]          rd_addr;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in, tap_prod;
   logic signed [ACC_BITS-1:0]    acc_rnd;
   logic signed [SAMPLE_BITS-1:0] rev_ff;
   logic [14:0]                   decay_eff;
   logic [15:0]                   mix_eff, dry_eff;
   logic signed [SAMPLE_BITS+15:0] p_dr_ff;
   logic signed [SAMPLE_BITS+16:0] p_mr_ff, p_mx_ff;
   logic signed [SUM_BITS-1:0]    w_sum, y_sum;
   logic signed [SAMPLE_BITS-1:0] wr_val, y_val, out_ff;
   logic                          mem_we;
   logic signed [SAMPLE_BITS-1:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_delay_one_ff   <= RST_TAP_DELAY_ONE;
         tap_delay_two_ff   <= RST_TAP_DELAY_TWO;
         tap_delay_three_ff <= RST_TAP_DELAY_THREE;
         decay_gain_ff      <= RST_DECAY_GAIN;
         wet_mix_ff         <= RST_WET_MIX;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TAP_DELAY_ONE:   tap_delay_one_ff   <= csr_write_data;
            CSR_TAP_DELAY_TWO:   tap_delay_two_ff   <= csr_write_data;
            CSR_TAP_DELAY_THREE: tap_delay_three_ff <= csr_write_data;
            CSR_DECAY_GAIN:      decay_gain_ff      <= csr_write_data[14:0];
            CSR_WET_MIX:         wet_mix_ff         <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // delay mod depth: reciprocal estimate, then one correction
   always_comb begin
      unique case (cmd.quo_sel)
         TAP_ONE:   d_sel = tap_delay_one_ff;
         TAP_TWO:   d_sel = tap_delay_two_ff;
         TAP_THREE: d_sel = tap_delay_three_ff;
         default:   d_sel = tap_delay_one_ff;
      endcase
   end

   assign qprod  = QP_BITS'(d_sel) * QP_BITS'(RECIP);
   assign q_in   = DELAY_BITS'(qprod >> QSH);
   assign qd     = RP_BITS'(q_ff) * RP_BITS'(BUFFER_DEPTH);
   assign diff   = RP_BITS'(dq_ff) - qd;
   assign rem_in = (diff >= RP_BITS'(BUFFER_DEPTH)) ?
                   ADDR_BITS'(diff - RP_BITS'(BUFFER_DEPTH)) : ADDR_BITS'(diff);

   always_comb begin
      if (wp_ff >= rem_ff) begin
         rd_addr_wide = {1'b0, wp_ff} - {1'b0, rem_ff};
      end else begin
         rd_addr_wide = {1'b0, wp_ff} + (ADDR_BITS+1)'(BUFFER_DEPTH) - {1'b0, rem_ff};
      end
   end
   assign rd_addr = rd_addr_wide[ADDR_BITS-1:0];

   assign tap_prod = ACC_BITS'(rd_data_ff) * $signed({1'b0, tap_weight(cmd.acc_sel)});
   assign acc_in   = cmd.acc_clr ? tap_prod : acc_ff + tap_prod;
   assign acc_rnd  = acc_ff + ACC_BITS'(ROUND_REV);

   assign decay_eff = (decay_gain_ff > DECAY_LIMIT) ? DECAY_LIMIT : decay_gain_ff;
   assign mix_eff   = (wet_mix_ff > MIX_LIMIT) ? MIX_LIMIT : wet_mix_ff;
   assign dry_eff   = Q15_ONE - mix_eff;

   assign w_sum  = (SUM_BITS'(x_ff) <<< Q15_SHIFT) + SUM_BITS'(p_dr_ff)
                   + SUM_BITS'(ROUND_Q15);
   assign y_sum  = SUM_BITS'(p_mx_ff) + SUM_BITS'(p_mr_ff) + SUM_BITS'(ROUND_Q15);
   assign wr_val = sat(w_sum >>> Q15_SHIFT);
   assign y_val  = sat(y_sum >>> Q15_SHIFT);

   assign wp_in       = (wp_ff == ADDR_BITS'(BUFFER_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign sts.wp_last = (wp_ff == ADDR_BITS'(BUFFER_DEPTH - 1));
   assign mem_we      = cmd.finish | cmd.clr_step;
   assign mem_wdata   = cmd.finish ? wr_val : '0;
   assign out_sample  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else if (mem_we) begin
         wp_ff <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= mem_wdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_in) begin
         x_ff <= in_sample;
      end
      if (cmd.quo_en) begin
         dq_ff <= d_sel;
         q_ff  <= q_in;
      end
      if (cmd.rem_en) begin
         rem_ff <= rem_in;
      end
      if (cmd.acc_en) begin
         acc_ff <= acc_in;
      end
      if (cmd.rev_en) begin
         rev_ff <= SAMPLE_BITS'(acc_rnd >>> REV_SHIFT);
      end
      if (cmd.mul_en) begin
         p_dr_ff <= $signed({1'b0, decay_eff}) * rev_ff;
         p_mr_ff <= $signed({1'b0, mix_eff}) * rev_ff;
         p_mx_ff <= $signed({1'b0, dry_eff}) * x_ff;
      end
      if (cmd.finish) begin
         out_ff <= y_val;
      end
   end

endmodule

### rtl/three_tap_feedback_reverb_core.sv
// Three-tap feedback reverb: items are taken one at a time, a new one only after the
// previous one has finished; the three tap reads follow the delay reduction and the
// write follows the multiply step, and finishing waits while a result is unaccepted.
// Reset (synchronous) runs a clearing pass over the delay memory with req ready
// low; config writes are taken throughout.
// Depends on tfrev_pkg, tfrev_if, tfrev_ctrl, tfrev_dp.
module three_tap_feedback_reverb_core import tfrev_pkg::*; #(
   parameter int BUFFER_DEPTH = 65536,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   tfrev_req_if.sink                req_chan,
   tfrev_rsp_if.source              rsp_chan,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data
);

   tfrev_cmd_type cmd;
   tfrev_sts_type sts;

   tfrev_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tfrev_dp #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .in_sample      (req_chan.sample_in),
      .out_sample     (rsp_chan.sample_out)
   );

endmodule

### rtl/tfrev_checker.sv
// Port-level checks for the reverb core, bound to the top level.
// Depends on three_tap_feedback_reverb_core.
module tfrev_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_sample_out
);

   logic [2:0] cnt_ff, cnt_in;

   assign cnt_in = cnt_ff + 3'(req_valid && req_ready) - 3'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("response dropped or changed while stalled");

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != 3'd0)
      else $error("response without an outstanding item");

   a_max_items: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd2)
      else $error("more than two items in flight");

   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !req_ready && !rsp_valid)
      else $error("handshake active right after reset");

endmodule

bind three_tap_feedback_reverb_core tfrev_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_tfrev_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_sample_out (rsp_chan.sample_out)
);

### tb/reverb_checker.sv
`timescale 1ns / 1ps
// Response checker for the three-tap feedback reverb. It mirrors the delay memory
// and the registers, predicts each sample_out and compares it in order.
// Depends on tfrev_pkg and tfrev_if.
module reverb_checker
   import tfrev_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   tfrev_req_if                     req_chan,
   tfrev_rsp_if                     rsp_chan,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data,
   output int                       pending_count,
   output int                       mismatch_count
);

   localparam int     MEM_DEPTH    = 65536;
   localparam longint TAP1_Q16     = 21845;
   localparam longint TAP2_Q16     = 15292;
   localparam longint TAP3_Q16     = 10923;
   localparam longint FEEDBACK_MAX = 32440;
   localparam longint WET_MAX      = 32768;
   localparam longint UNITY_Q15    = 32768;
   localparam longint SAMPLE_MAX   = 32767;
   localparam longint SAMPLE_MIN   = -32768;

   logic signed [15:0] echo_mem [MEM_DEPTH];
   logic        [15:0] head;
   logic        [15:0] delay_a;
   logic        [15:0] delay_b;
   logic        [15:0] delay_c;
   logic        [14:0] feedback;
   logic        [15:0] wet;
   logic signed [15:0] expected_q [$];
   int                 errors = 0;

   function automatic logic signed [15:0] clamp_sample(input longint v);
      if (v > SAMPLE_MAX) return 16'sh7FFF;
      if (v < SAMPLE_MIN) return 16'sh8000;
      return v[15:0];
   endfunction

   // zero delay lands on the word about to be overwritten
   function automatic logic signed [15:0] tap_read(input logic [15:0] lag);
      logic [15:0] idx;
      idx = head - lag;
      return echo_mem[idx];
   endfunction

   // one sample through the taps: updates memory and pointer, returns the mix
   function automatic logic signed [15:0] mix_and_feed_back(input logic signed [15:0] dry);
      longint x;
      longint t1;
      longint t2;
      longint t3;
      longint g;
      longint m;
      longint rev;
      logic signed [15:0] mixed;
      x  = dry;
      t1 = tap_read(delay_a);
      t2 = tap_read(delay_b);
      t3 = tap_read(delay_c);
      g  = feedback;
      m  = wet;
      if (g > FEEDBACK_MAX) g = FEEDBACK_MAX;
      if (m > WET_MAX) m = WET_MAX;
      rev = (t1 * TAP1_Q16 + t2 * TAP2_Q16 + t3 * TAP3_Q16 + 32768) >>> 16;
      echo_mem[head] = clamp_sample((x * UNITY_Q15 + g * rev + 16384) >>> 15);
      mixed = clamp_sample(((UNITY_Q15 - m) * x + m * rev + 16384) >>> 15);
      head = head + 16'd1;
      return mixed;
   endfunction

   always @(posedge clock) begin
      logic signed [15:0] want;
      if (reset) begin
         for (int i = 0; i < MEM_DEPTH; i++) echo_mem[i] = '0;
         head     = '0;
         delay_a  = 16'd4800;
         delay_b  = 16'd6720;
         delay_c  = 16'd9120;
         feedback = 15'd16384;
         wet      = 16'd16384;
         expected_q.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_TAP_DELAY_ONE:   delay_a  = csr_write_data;
               CSR_TAP_DELAY_TWO:   delay_b  = csr_write_data;
               CSR_TAP_DELAY_THREE: delay_c  = csr_write_data;
               CSR_DECAY_GAIN:      feedback = csr_write_data[14:0];
               CSR_WET_MIX:         wet      = csr_write_data;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready)
            expected_q.push_back(mix_and_feed_back(req_chan.sample_in));
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("ERROR: unexpected sample_out %0d with nothing outstanding",
                           rsp_chan.sample_out);
            end else begin
               want = expected_q.pop_front();
               if (rsp_chan.sample_out !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("ERROR: sample_out expected %0d, got %0d at %0t",
                              want, rsp_chan.sample_out, $realtime);
               end
            end
         end
      end
      pending_count  <= expected_q.size();
      mismatch_count <= errors;
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the reverb testbench: clock, reset, register settings, sample stimulus
// with bursts and response stalls, and the verdict.
// Depends on tfrev_pkg, tfrev_if, three_tap_feedback_reverb_core, reverb_checker.
module testbench;
   import tfrev_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED = 3'd5;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_SAMPLES = 250;
   localparam int LONG_HOLD     = 400;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_write_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_write_data;
   int                       pending_count;
   int                       mismatch_count;
   int                       hold_requests;
   int                       holds_served;
   int                       samples_sent;
   int                       phases_run;

   tfrev_req_if #(.SAMPLE_BITS(16)) req_bus ();
   tfrev_rsp_if #(.SAMPLE_BITS(16)) rsp_bus ();

   three_tap_feedback_reverb_core #(
      .BUFFER_DEPTH(65536),
      .SAMPLE_BITS (16)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_bus),
      .rsp_chan      (rsp_bus),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_write_data(csr_write_data)
   );

   reverb_checker reverb_check (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_bus),
      .rsp_chan      (rsp_bus),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_write_data(csr_write_data),
      .pending_count (pending_count),
      .mismatch_count(mismatch_count)
   );

   always #4 clock = ~clock;

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [15:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
   endtask

   task automatic send_sample(input logic signed [15:0] s);
      req_bus.valid     <= 1'b1;
      req_bus.sample_in <= s;
      do @(posedge clock); while (!req_bus.ready);
      samples_sent++;
   endtask

   // valid must already be low
   task automatic drain_results;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_delay();
      case ($urandom_range(0, 5))
         0:       return 16'($urandom_range(0, 8));
         1:       return 16'($urandom_range(1, 64));
         2:       return 16'($urandom_range(1, 400));
         3:       return 16'($urandom_range(1, 2500));
         4:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_decay();
      case ($urandom_range(0, 4))
         0:       return 16'd0;
         1:       return {1'($urandom), 15'd32440};
         2:       return 16'($urandom_range(32441, 32767)) | 16'($urandom_range(0, 1) << 15);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_mix();
      case ($urandom_range(0, 4))
         0:       return 16'd0;
         1:       return 16'd32768;
         2:       return 16'($urandom_range(32769, 65535));
         default: return 16'($urandom_range(0, 32768));
      endcase
   endfunction

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'($urandom_range(0, 63) - 32);
         3:       return 16'($urandom_range(0, 8191) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic load_random_settings;
      write_reg(CSR_TAP_DELAY_ONE, pick_delay());
      write_reg(CSR_TAP_DELAY_TWO, pick_delay());
      write_reg(CSR_TAP_DELAY_THREE, pick_delay());
      write_reg(CSR_DECAY_GAIN, pick_decay());
      write_reg(CSR_WET_MIX, pick_mix());
      write_reg(CSR_UNMAPPED + 3'($urandom_range(0, 2)), 16'($urandom));
      csr_write_en <= 1'b0;
   endtask

   task automatic run_random_phase(input int count, input bit calm);
      int burst_left;
      int gap;
      burst_left = 0;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = calm ? 0 : $urandom_range(0, 12);
            if (gap != 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         send_sample(pick_sample());
      end
      req_bus.valid <= 1'b0;
   endtask

   // response side: changing stall patterns, plus long hold-offs on request
   initial begin
      int mode;
      int run_left;
      rsp_bus.ready = 1'b0;
      holds_served  = 0;
      mode          = 0;
      run_left      = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_served++;
         end else begin
            if (run_left == 0) begin
               mode     = $urandom_range(0, 3);
               run_left = $urandom_range(20, 200);
            end
            run_left--;
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= ($urandom_range(0, 9) == 0);
               default: rsp_bus.ready <= run_left[0];
            endcase
         end
      end
   end

   initial begin
      logic signed [15:0] edge_samples [7];
      edge_samples = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF,
                       16'sh5555, 16'shAAAA};
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.sample_in = '0;
      csr_write_en      = 1'b0;
      csr_index         = CSR_TAP_DELAY_ONE;
      csr_write_data    = '0;
      hold_requests     = 0;
      samples_sent      = 0;
      phases_run        = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings, taps still on cleared memory
      foreach (edge_samples[i]) send_sample(edge_samples[i]);
      req_bus.valid <= 1'b0;
      drain_results();
      phases_run++;

      // zero and short delays, gains above their limits, unmapped indexes
      write_reg(CSR_TAP_DELAY_ONE, 16'd0);
      write_reg(CSR_TAP_DELAY_TWO, 16'd1);
      write_reg(CSR_TAP_DELAY_THREE, 16'd2);
      write_reg(CSR_DECAY_GAIN, 16'hFFFF);
      write_reg(CSR_WET_MIX, 16'hFFFF);
      for (int k = 0; k < 3; k++) write_reg(CSR_UNMAPPED + 3'(k), 16'h0001);
      csr_write_en <= 1'b0;
      for (int i = 0; i < 11; i++)
         send_sample(i < 4 ? 16'sh7FFF : (i < 8 ? 16'sh8000 : 16'sh0000));
      req_bus.valid <= 1'b0;
      drain_results();
      phases_run++;

      // longest delays, no feedback, fully dry
      write_reg(CSR_TAP_DELAY_ONE, 16'hFFFF);
      write_reg(CSR_TAP_DELAY_TWO, 16'hFFFF);
      write_reg(CSR_TAP_DELAY_THREE, 16'hFFFF);
      write_reg(CSR_DECAY_GAIN, 16'd0);
      write_reg(CSR_WET_MIX, 16'd0);
      csr_write_en <= 1'b0;
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh3039);
      req_bus.valid <= 1'b0;
      drain_results();
      phases_run++;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         load_random_settings();
         if (p == 2) hold_requests <= hold_requests + 1;
         run_random_phase(PHASE_SAMPLES, p == 2 || p == 5);
         drain_results();
         phases_run++;
      end

      repeat (20) @(posedge clock);
      $display("Covered %0d samples over %0d register settings, with a long response hold-off.",
               samples_sent, phases_run);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Timeout waiting for results");
      $display("Mismatches found");
      $finish;
   end

endmodule
